FILE: design/imgrot_pkg.sv
// ----------------------------------------------------------------------------
// imgrot_pkg
// Shared types and constants of the quarter-turn rotating frame store:
// request and response payloads, a pixel type, register indexes, action and
// mode codes and register reset values.
// ----------------------------------------------------------------------------
package imgrot_pkg;

	localparam int MAX_SIDE_DEF = 256;

	localparam int SIDE_W     = 9;
	localparam int COORD_W    = 8;
	localparam int CHAN_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SECTION_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_X        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_Y        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SEL_SIZE     = 3'd6;

	// register reset values
	localparam logic [SIDE_W-1:0]  RST_SRC_WIDTH  = 9'd256;
	localparam logic [SIDE_W-1:0]  RST_SRC_HEIGHT = 9'd256;
	localparam logic [COORD_W-1:0] RST_SEL_X      = 8'd0;
	localparam logic [COORD_W-1:0] RST_SEL_Y      = 8'd0;
	localparam logic [SIDE_W-1:0]  RST_SEL_SIZE   = 9'd1;

	// action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// color and section mode codes
	localparam logic COLOR_GREY  = 1'b0;
	localparam logic COLOR_RGB   = 1'b1;
	localparam logic SECT_WHOLE  = 1'b0;
	localparam logic SECT_SELECT = 1'b1;

	typedef struct packed {
		logic              action;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [CHAN_W-1:0]  red_in;
		logic [CHAN_W-1:0]  green_in;
		logic [CHAN_W-1:0]  blue_in;
	} req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic              out_of_range;
	} rsp_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

endpackage

FILE: design/image_rotate_quarter_turn_core.sv
// ----------------------------------------------------------------------------
// image_rotate_quarter_turn_core
// Frame store with a quarter-turn rotated read view, whole image or square
// selection in place, grey or three-channel pixels.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless a held response stalls it. A
// load writes its pixel into the frame memory in the cycle after it is
// accepted; a read is mapped to a source address in the accept cycle, reads
// the single-port frame memory once the response register is free and offers
// its response from that register. Loads and reads stream at one request per
// cycle, the one memory access per cycle being what sets that figure. A load
// just ahead of a read to the same pixel is seen by that read. Loads give no
// response. The memory holds 2**(2*AW) pixels and needs no clearing after
// reset; reading a pixel that was never loaded returns undefined data.
module image_rotate_quarter_turn_core #(
	parameter int MAX_SIDE = imgrot_pkg::MAX_SIDE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  imgrot_pkg::req_t                 req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output imgrot_pkg::rsp_t                 rsp,
	input  logic                             cfg_we,
	input  logic [imgrot_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [imgrot_pkg::CFG_DATA_W-1:0] cfg_data
);
	import imgrot_pkg::*;

	localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int CW    = (AW > SIDE_W) ? AW : SIDE_W;
	localparam int DEPTH = 2 ** (2 * AW);
	localparam logic [SIDE_W-1:0] SIDE_CLAMP = SIDE_W'((MAX_SIDE > 511) ? 511 : MAX_SIDE);

	// configuration registers
	logic [SIDE_W-1:0]  src_width_q, src_height_q, sel_size_q;
	logic [COORD_W-1:0] sel_x_q, sel_y_q;
	logic               color_mode_q, section_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q    <= RST_SRC_WIDTH;
			src_height_q   <= RST_SRC_HEIGHT;
			color_mode_q   <= COLOR_GREY;
			section_mode_q <= SECT_WHOLE;
			sel_x_q        <= RST_SEL_X;
			sel_y_q        <= RST_SEL_Y;
			sel_size_q     <= RST_SEL_SIZE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:    src_width_q    <= cfg_data;
				REG_SRC_HEIGHT:   src_height_q   <= cfg_data;
				REG_COLOR_MODE:   color_mode_q   <= cfg_data[0];
				REG_SECTION_MODE: section_mode_q <= cfg_data[0];
				REG_SEL_X:        sel_x_q        <= cfg_data[COORD_W-1:0];
				REG_SEL_Y:        sel_y_q        <= cfg_data[COORD_W-1:0];
				REG_SEL_SIZE:     sel_size_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// address mapping, accept cycle
	logic [SIDE_W-1:0]  w, h, row_x, col_x;
	logic [SIDE_W:0]    sel_ye, sel_xe, sect_sr;
	logic [COORD_W-1:0] sel_i, sel_j;
	logic [SIDE_W-1:0]  map_sr, map_sc, sect_sc;
	logic               map_inside, sel_ok, in_sel, load_ok;
	logic [CW-1:0]      sr_ext, sc_ext;
	logic [2*AW-1:0]    map_addr;
	pixel_t             load_pix;

	always_comb begin
		w      = (src_width_q > SIDE_CLAMP) ? SIDE_CLAMP : src_width_q;
		h      = (src_height_q > SIDE_CLAMP) ? SIDE_CLAMP : src_height_q;
		row_x  = {1'b0, req.row};
		col_x  = {1'b0, req.col};
		sel_ye = {2'b00, sel_y_q} + {1'b0, sel_size_q};
		sel_xe = {2'b00, sel_x_q} + {1'b0, sel_size_q};
		sel_ok = (sel_size_q != '0) && (sel_ye <= {1'b0, h}) && (sel_xe <= {1'b0, w});
		in_sel = (req.row >= sel_y_q) && ({2'b00, req.row} < sel_ye)
			&& (req.col >= sel_x_q) && ({2'b00, req.col} < sel_xe);
		sel_i   = req.row - sel_y_q;
		sel_j   = req.col - sel_x_q;
		sect_sr = sel_ye - 1'b1 - {2'b00, sel_j};
		sect_sc = {1'b0, sel_x_q} + {1'b0, sel_i};
		load_ok = (row_x < h) && (col_x < w);

		if (req.action == ACT_LOAD) begin
			map_inside = load_ok;
			map_sr     = row_x;
			map_sc     = col_x;
		end else if (section_mode_q == SECT_WHOLE) begin
			// output is w rows by h columns
			map_inside = (row_x < w) && (col_x < h);
			map_sr     = h - 1'b1 - col_x;
			map_sc     = row_x;
		end else begin
			map_inside = load_ok;
			map_sr     = row_x;
			map_sc     = col_x;
			if (sel_ok && in_sel) begin
				map_sr = sect_sr[SIDE_W-1:0];
				map_sc = sect_sc;
			end
		end

		sr_ext   = CW'(map_sr);
		sc_ext   = CW'(map_sc);
		map_addr = {sr_ext[AW-1:0], sc_ext[AW-1:0]};

		load_pix.red   = req.red_in;
		load_pix.green = (color_mode_q == COLOR_RGB) ? req.green_in : '0;
		load_pix.blue  = (color_mode_q == COLOR_RGB) ? req.blue_in : '0;
	end

	// pipeline control
	logic            valid_s1, act_s1, inside_s1;
	logic [2*AW-1:0] addr_s1;
	pixel_t          pix_s1;
	logic            valid_s2, inside_s2;
	pixel_t          rdata_s2;
	logic            s2_busy, s1_done, req_take, mem_we, mem_re;

	assign s2_busy   = valid_s2 && rsp_stall;
	assign s1_done   = valid_s1 && ((act_s1 == ACT_LOAD) || !s2_busy);
	assign req_stall = valid_s1 && !s1_done;
	assign req_take  = req_valid && !req_stall;
	assign mem_we    = valid_s1 && (act_s1 == ACT_LOAD) && inside_s1;
	assign mem_re    = valid_s1 && (act_s1 == ACT_READ) && !s2_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_take)
				valid_s1 <= 1'b1;
			else if (s1_done)
				valid_s1 <= 1'b0;
			if (!s2_busy)
				valid_s2 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			act_s1    <= req.action;
			inside_s1 <= map_inside;
			addr_s1   <= map_addr;
			pix_s1    <= load_pix;
		end
		if (mem_re)
			inside_s2 <= inside_s1;
	end

	// frame memory, one access per cycle
	pixel_t frame_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we)
			frame_mem[addr_s1] <= pix_s1;
		if (mem_re)
			rdata_s2 <= frame_mem[addr_s1];
	end

	// response
	always_comb begin
		rsp_valid        = valid_s2;
		rsp.red_out      = inside_s2 ? rdata_s2.red : '0;
		rsp.green_out    = (inside_s2 && color_mode_q == COLOR_RGB) ? rdata_s2.green : '0;
		rsp.blue_out     = (inside_s2 && color_mode_q == COLOR_RGB) ? rdata_s2.blue : '0;
		rsp.out_of_range = !inside_s2;
	end

`ifndef ASSERT_OFF
	a_grey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && color_mode_q == COLOR_GREY |-> rsp.green_out == '0 && rsp.blue_out == '0)
		else $error("grey mode response carries green or blue");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_of_range |->
			rsp.red_out == '0 && rsp.green_out == '0 && rsp.blue_out == '0)
		else $error("out of range response carries pixel data");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> valid_s1 && act_s1 == $past(req.action))
		else $error("accepted request lost before the memory stage");

	a_load_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && act_s1 == ACT_LOAD && !s2_busy |=> !valid_s2)
		else $error("load produced a response");
`endif

endmodule

FILE: sim/tb_image_rotate_quarter_turn_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_rotate_quarter_turn_core
// Loads pixels into the frame store and reads back the quarter-turn view, in
// whole-image and selection modes, grey and three-channel, over many frame and
// selection settings. Every response is checked against a bench frame copy or
// a fixed value, under random request gaps and response back-pressure.
// ----------------------------------------------------------------------------
module tb_image_rotate_quarter_turn_core;
	import imgrot_pkg::*;

	localparam int CYCLE_LIMIT      = 200000;
	localparam int SETTLE_CYCLES    = 4;
	localparam int TAIL_CYCLES      = 8;
	localparam int BLOCK_ITEMS      = 30;
	localparam int BLOCKS_PER_PHASE = 6;
	localparam int FRAME_ENTRIES    = MAX_SIDE_DEF * MAX_SIDE_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		req_t                  item;
		bit                    typed;
		rsp_t                  want;
	} step_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// bench copy of the frame and the registers
	pixel_t             frame_copy [FRAME_ENTRIES];
	bit                 pixel_loaded [FRAME_ENTRIES];
	logic [SIDE_W-1:0]  width_reg   = RST_SRC_WIDTH;
	logic [SIDE_W-1:0]  height_reg  = RST_SRC_HEIGHT;
	logic               color_reg   = COLOR_GREY;
	logic               section_reg = SECT_WHOLE;
	logic [COORD_W-1:0] selx_reg    = RST_SEL_X;
	logic [COORD_W-1:0] sely_reg    = RST_SEL_Y;
	logic [SIDE_W-1:0]  selsize_reg = RST_SEL_SIZE;

	rsp_t pending_pixels [$];
	int   fail_count   = 0;
	int   cycle_count  = 0;
	int   req_idle_pct = 0;
	int   rsp_idle_pct = 0;

	image_rotate_quarter_turn_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int clamp_side(input logic [SIDE_W-1:0] v);
		return (v > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(v);
	endfunction

	// source pixel behind an output position under the current settings
	function automatic void map_source(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
		output bit in_frame, output int src_r, output int src_c);
		int w, h, n, x0, y0, rr, cc;
		w = clamp_side(width_reg);
		h = clamp_side(height_reg);
		n = int'(selsize_reg);
		x0 = int'(selx_reg);
		y0 = int'(sely_reg);
		rr = int'(r);
		cc = int'(c);
		if (section_reg == SECT_WHOLE) begin
			// output is w rows by h columns
			in_frame = (rr < w) && (cc < h);
			src_r = in_frame ? h - 1 - cc : 0;
			src_c = rr;
		end else begin
			in_frame = (rr < h) && (cc < w);
			src_r = rr;
			src_c = cc;
			if (n != 0 && y0 + n <= h && x0 + n <= w &&
				rr >= y0 && rr < y0 + n && cc >= x0 && cc < x0 + n) begin
				src_r = y0 + n - 1 - (cc - x0);
				src_c = x0 + (rr - y0);
			end
		end
	endfunction

	// apply one request to the frame copy; returns 1 with the pixel a read yields
	function automatic bit predict_frame_access(input req_t item, output rsp_t pix_out);
		pixel_t pix;
		bit     in_frame;
		int     sr, sc;
		pix_out = '0;
		if (item.action == ACT_LOAD) begin
			if (item.row < clamp_side(height_reg) && item.col < clamp_side(width_reg)) begin
				pix.red   = item.red_in;
				pix.green = (color_reg == COLOR_GREY) ? '0 : item.green_in;
				pix.blue  = (color_reg == COLOR_GREY) ? '0 : item.blue_in;
				frame_copy[{item.row, item.col}]   = pix;
				pixel_loaded[{item.row, item.col}] = 1'b1;
			end
			return 1'b0;
		end
		map_source(item.row, item.col, in_frame, sr, sc);
		pix = in_frame ? frame_copy[sr * MAX_SIDE_DEF + sc] : '0;
		if (color_reg == COLOR_GREY) begin
			pix.green = '0;
			pix.blue  = '0;
		end
		pix_out.red_out      = pix.red;
		pix_out.green_out    = pix.green;
		pix_out.blue_out     = pix.blue;
		pix_out.out_of_range = !in_frame;
		return 1'b1;
	endfunction

	task automatic send_request(input req_t item, input bit typed, input rsp_t want);
		rsp_t pix_out;
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall !== 1'b0);
		if (predict_frame_access(item, pix_out))
			pending_pixels.push_back(typed ? want : pix_out);
	endtask

	task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		req_valid <= 1'b0;
		// drain, then let a trailing load land
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SRC_WIDTH:    width_reg = val;
			REG_SRC_HEIGHT:   height_reg = val;
			REG_COLOR_MODE:   color_reg = val[0];
			REG_SECTION_MODE: section_reg = val[0];
			REG_SEL_X:        selx_reg = val[COORD_W-1:0];
			REG_SEL_Y:        sely_reg = val[COORD_W-1:0];
			REG_SEL_SIZE:     selsize_reg = val;
			default: ;
		endcase
	endtask

	function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		step_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.data = data;
		return s;
	endfunction

	function automatic step_t load_step(input logic [7:0] row, input logic [7:0] col,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		step_t s;
		s = '{default: '0};
		s.item = '{action: ACT_LOAD, row: row, col: col, red_in: r, green_in: g, blue_in: b};
		return s;
	endfunction

	function automatic step_t read_step(input logic [7:0] row, input logic [7:0] col);
		step_t s;
		s = '{default: '0};
		s.item = '{action: ACT_READ, row: row, col: col, red_in: '0, green_in: '0, blue_in: '0};
		return s;
	endfunction

	function automatic step_t read_known(input logic [7:0] row, input logic [7:0] col,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, input logic oor);
		step_t s;
		s = read_step(row, col);
		s.typed = 1'b1;
		s.want = '{red_out: r, green_out: g, blue_out: b, out_of_range: oor};
		return s;
	endfunction

	function automatic logic [SIDE_W-1:0] side_choice();
		case ($urandom_range(9))
			0: return 9'd1;
			1: return 9'd256;
			2: return SIDE_W'($urandom_range(511, 257));
			3, 4: return SIDE_W'($urandom_range(256, 1));
			default: return SIDE_W'($urandom_range(16, 1));
		endcase
	endfunction

	task automatic pick_config();
		logic [SIDE_W-1:0]  wv, hv, nv;
		logic [COORD_W-1:0] xv, yv;
		int                 w, h, lim, n;
		wv = side_choice();
		hv = side_choice();
		w = clamp_side(wv);
		h = clamp_side(hv);
		lim = (w < h) ? w : h;
		if ($urandom_range(4) == 0) begin
			// any size and place, often not inside the frame
			nv = SIDE_W'($urandom_range(511, 0));
			xv = COORD_W'($urandom_range(255, 0));
			yv = COORD_W'($urandom_range(255, 0));
		end else begin
			n = (lim > 16 && $urandom_range(3) != 0) ? $urandom_range(16, 1) : $urandom_range(lim, 1);
			nv = SIDE_W'(n);
			xv = COORD_W'($urandom_range(w - n, 0));
			yv = COORD_W'($urandom_range(h - n, 0));
		end
		set_register(REG_SRC_WIDTH, wv);
		set_register(REG_SRC_HEIGHT, hv);
		set_register(REG_COLOR_MODE, CFG_DATA_W'($urandom_range(1) ? COLOR_RGB : COLOR_GREY));
		set_register(REG_SECTION_MODE,
			CFG_DATA_W'($urandom_range(1) ? SECT_SELECT : SECT_WHOLE));
		set_register(REG_SEL_X, CFG_DATA_W'(xv));
		set_register(REG_SEL_Y, CFG_DATA_W'(yv));
		set_register(REG_SEL_SIZE, nv);
	endtask

	task automatic run_block(input int target);
		req_t item, fill;
		bit   in_frame, fits;
		int   counted, w, h, n, orows, ocols, sr, sc;
		counted = 0;
		while (counted < target) begin
			w = clamp_side(width_reg);
			h = clamp_side(height_reg);
			item.red_in   = 8'($urandom_range(255));
			item.green_in = 8'($urandom_range(255));
			item.blue_in  = 8'($urandom_range(255));
			if ($urandom_range(9) < 4) begin
				item.action = ACT_LOAD;
				if (w > 0 && h > 0 && $urandom_range(9) != 0) begin
					item.row = 8'($urandom_range(h - 1));
					item.col = 8'($urandom_range(w - 1));
				end else begin
					item.row = 8'($urandom_range(255));
					item.col = 8'($urandom_range(255));
				end
				if (item.row < h && item.col < w)
					counted++;
				send_request(item, 1'b0, '0);
			end else begin
				item.action = ACT_READ;
				orows = (section_reg == SECT_WHOLE) ? w : h;
				ocols = (section_reg == SECT_WHOLE) ? h : w;
				n = int'(selsize_reg);
				fits = section_reg == SECT_SELECT && n != 0 &&
					sely_reg + n <= h && selx_reg + n <= w;
				if (fits && $urandom_range(1)) begin
					item.row = 8'(sely_reg + $urandom_range(n - 1));
					item.col = 8'(selx_reg + $urandom_range(n - 1));
				end else if (orows > 0 && ocols > 0 && $urandom_range(4) != 0) begin
					item.row = 8'($urandom_range(orows - 1));
					item.col = 8'($urandom_range(ocols - 1));
				end else begin
					item.row = 8'($urandom_range(255));
					item.col = 8'($urandom_range(255));
				end
				map_source(item.row, item.col, in_frame, sr, sc);
				// load the source pixel first if it was never written
				if (in_frame && !pixel_loaded[sr * MAX_SIDE_DEF + sc]) begin
					fill = item;
					fill.action = ACT_LOAD;
					fill.row = 8'(sr);
					fill.col = 8'(sc);
					send_request(fill, 1'b0, '0);
					counted++;
				end
				send_request(item, 1'b0, '0);
				counted++;
			end
		end
	endtask

	function automatic void compare_field(input string name, input logic [CHAN_W-1:0] expv,
		input logic [CHAN_W-1:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %0h, got %0h", name, expv, actv);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("response with no request pending: %0h", rsp);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				compare_field("red_out", want.red_out, rsp.red_out);
				compare_field("green_out", want.green_out, rsp.green_out);
				compare_field("blue_out", want.blue_out, rsp.blue_out);
				compare_field("out_of_range", CHAN_W'(want.out_of_range),
					CHAN_W'(rsp.out_of_range));
			end
		end
	end

	initial begin : stimulus
		step_t dir_steps [$];
		dir_steps = '{
			load_step(8'd255, 8'd0, 8'hFF, 8'hFF, 8'hFF),
			// grey mode drops green and blue
			read_known(8'd0, 8'd0, 8'hFF, 8'h00, 8'h00, 1'b0),
			load_step(8'd0, 8'd255, 8'h00, 8'hAA, 8'h55),
			read_known(8'd255, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0),
			load_step(8'd1, 8'd5, 8'h5A, 8'hC3, 8'h3C),
			cfg_step(REG_COLOR_MODE, CFG_DATA_W'(COLOR_RGB)),
			load_step(8'd128, 8'd127, 8'h80, 8'h7F, 8'h01),
			read_known(8'd127, 8'd127, 8'h80, 8'h7F, 8'h01, 1'b0),
			load_step(8'd255, 8'd255, 8'hFF, 8'hFF, 8'hFF),
			read_known(8'd255, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0),
			read_known(8'd5, 8'd254, 8'h5A, 8'h00, 8'h00, 1'b0),
			// 3 columns by 2 rows gives an output of 3 rows by 2 columns
			cfg_step(REG_SRC_WIDTH, 9'd3),
			cfg_step(REG_SRC_HEIGHT, 9'd2),
			load_step(8'd0, 8'd2, 8'h11, 8'h22, 8'h33),
			read_known(8'd2, 8'd1, 8'h11, 8'h22, 8'h33, 1'b0),
			// drop loads outside the frame
			load_step(8'd1, 8'd5, 8'hFF, 8'hFF, 8'hFF),
			load_step(8'd2, 8'd0, 8'h12, 8'h34, 8'h56),
			read_known(8'd3, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1),
			read_known(8'd0, 8'd2, 8'h00, 8'h00, 8'h00, 1'b1),
			// empty frame
			cfg_step(REG_SRC_WIDTH, 9'd0),
			load_step(8'd0, 8'd0, 8'h77, 8'h77, 8'h77),
			read_known(8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1),
			// oversize sides saturate at the store side
			cfg_step(REG_SRC_WIDTH, 9'd511),
			cfg_step(REG_SRC_HEIGHT, 9'd300),
			read_known(8'd5, 8'd254, 8'h5A, 8'h00, 8'h00, 1'b0),
			cfg_step(REG_SECTION_MODE, CFG_DATA_W'(SECT_SELECT)),
			cfg_step(REG_SEL_X, 9'd1),
			cfg_step(REG_SEL_Y, 9'd1),
			cfg_step(REG_SEL_SIZE, 9'd2),
			load_step(8'd2, 8'd1, 8'h0C, 8'h0D, 8'h0E),
			read_known(8'd1, 8'd1, 8'h0C, 8'h0D, 8'h0E, 1'b0),
			// outside the selection the pixel passes through
			read_known(8'd128, 8'd127, 8'h80, 8'h7F, 8'h01, 1'b0),
			// selection runs past the right edge: no rotation
			cfg_step(REG_SEL_X, 9'd255),
			read_known(8'd2, 8'd1, 8'h0C, 8'h0D, 8'h0E, 1'b0),
			cfg_step(REG_SEL_X, 9'd1),
			cfg_step(REG_SEL_SIZE, 9'd0),
			read_step(8'd2, 8'd1),
			// selection covering the whole frame
			cfg_step(REG_SEL_X, 9'd0),
			cfg_step(REG_SEL_Y, 9'd0),
			cfg_step(REG_SEL_SIZE, 9'd256),
			read_known(8'd0, 8'd0, 8'hFF, 8'h00, 8'h00, 1'b0),
			cfg_step(REG_UNUSED, 9'h1FF),
			// grey read of a three-channel pixel
			cfg_step(REG_COLOR_MODE, CFG_DATA_W'(COLOR_GREY)),
			read_known(8'd255, 8'd0, 8'hFF, 8'h00, 8'h00, 1'b0),
			read_step(8'd255, 8'd255)
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_steps[k]) begin
			if (dir_steps[k].is_cfg)
				set_register(dir_steps[k].idx, dir_steps[k].data);
			else
				send_request(dir_steps[k].item, dir_steps[k].typed, dir_steps[k].want);
		end
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					req_idle_pct = 28;
					rsp_idle_pct = 65;
				end
				1: begin
					req_idle_pct = 65;
					rsp_idle_pct = 28;
				end
				default: begin
					req_idle_pct = 0;
					rsp_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
				pick_config();
				run_block(BLOCK_ITEMS);
			end
		end
		req_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: image_rotate_quarter_turn_core.f
design/imgrot_pkg.sv
design/image_rotate_quarter_turn_core.sv
sim/tb_image_rotate_quarter_turn_core.sv
